// File: sv/plint_pkg.sv
// Shared constants, register codes and fixed-point helpers for the Phong
// light intensity pipeline. No dependencies.
`default_nettype none

package plint_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;

  // field widths
  localparam int IN_W   = 28;            // point, normal and light components
  localparam int VW     = IN_W + 1;      // eye and light vectors before normalising
  localparam int MW     = IN_W;          // component magnitudes
  localparam int SQ_W   = 2 * MW;        // squared magnitude
  localparam int SUM_W  = SQ_W + 2;      // sum of three squares
  localparam int ROOT_W = SUM_W / 2;     // vector length
  localparam int REM_W  = ROOT_W + 3;    // square root remainder
  localparam int DIV_W  = ROOT_W + 1;    // divider remainder
  localparam int QW     = FRAC_BITS + 1; // unsigned value in [0, ONE]
  localparam int UW     = FRAC_BITS + 2; // signed unit component
  localparam int DOT_W  = UW + 2;        // signed dot product
  localparam int RV_W   = UW + 3;        // signed reflected component
  localparam int TW     = 2 * UW + 12;   // wide scratch for sums of products
  localparam int WT_W   = 17;            // weight registers
  localparam int POW_W  = 6;             // exponent register
  localparam int OUT_W  = 17;
  localparam int QMW    = (QW + 1 > WT_W + 1) ? QW + 1 : WT_W + 1;
  localparam int WS_W   = WT_W + 3;
  localparam int OUT_LIM = (ONE > (1 << OUT_W) - 1) ? (1 << OUT_W) - 1 : ONE;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = IN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECULAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z  = 3'd5;

  // register reset values
  localparam logic [WT_W-1:0]  RST_AMBIENT  = 17'd13107;
  localparam logic [WT_W-1:0]  RST_DIFFUSE  = 17'd32768;
  localparam logic [POW_W-1:0] RST_SPECULAR = 6'd30;
  localparam logic [IN_W-1:0]  RST_LIGHT_X  = 28'd6553600;
  localparam logic [IN_W-1:0]  RST_LIGHT_Y  = 28'd6553600;
  localparam logic [IN_W-1:0]  RST_LIGHT_Z  = 28'hFCE0000;

  // latency of the normaliser and of the whole block, in cycles
  localparam int UNIT_LAT = 5 + ROOT_W + QW + 1;
  localparam int PIPE_LAT = UNIT_LAT + 15;

  // divide by ONE, truncating toward zero
  function automatic logic signed [TW-1:0] trunc_frac(input logic signed [TW-1:0] x);
    logic signed [TW-1:0] bias;
    bias = x[TW-1] ? TW'(ONE - 1) : '0;
    return (x + bias) >>> FRAC_BITS;
  endfunction

  // product of two unsigned Q values, floored
  function automatic logic [QMW-1:0] qmul(input logic [QMW-1:0] a, input logic [QMW-1:0] b);
    logic [2*QMW-1:0] prod;
    prod = a * b;
    return prod[FRAC_BITS +: QMW];
  endfunction

  // clamp a signed value into [0, ONE]
  function automatic logic [QW-1:0] clamp_unit(input logic signed [TW-1:0] x);
    logic [QW-1:0] res;
    if (x[TW-1]) begin
      res = '0;
    end else if (x > TW'(ONE)) begin
      res = QW'(ONE);
    end else begin
      res = x[QW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: sv/plint_unitize.sv
// Pipelined vector normaliser: scale up, sum of squares, bit-serial square
// root and restoring division, one stage per bit. Depends on plint_pkg.
`default_nettype none

module plint_unitize import plint_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [2:0][VW-1:0]     vec,
  output logic                   out_valid,
  output logic [2:0][UW-1:0]     unit
);

  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic               zero;
  } ucarry_t;

  // stage 0: magnitudes and signs
  logic [2:0][VW-1:0] abs_v;
  logic [2:0][MW-1:0] mag0_r;
  logic [2:0]         neg0_r;
  logic               v0_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = vec[i][VW-1] ? (~vec[i] + VW'(1)) : vec[i];
    end
  end

  always_ff @(posedge clk) begin
    v0_r <= rst_n ? in_valid : 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag0_r[i] <= abs_v[i][MW-1:0];
      neg0_r[i] <= vec[i][VW-1];
    end
  end

  // stage 1: largest magnitude, coarse normalising shifts
  logic [MW-1:0]      m_max, m_a, m_b;
  logic               sh16, sh8;
  logic [2:0][MW-1:0] t16, mag1;
  logic [MW-1:0]      m1_r;
  logic [2:0][MW-1:0] mag1_r;
  logic [2:0]         neg1_r;
  logic               zero1_r, v1_r;

  always_comb begin
    m_max = mag0_r[0];
    if (mag0_r[1] > m_max) m_max = mag0_r[1];
    if (mag0_r[2] > m_max) m_max = mag0_r[2];
    sh16 = (m_max[MW-1 -: 16] == '0);
    m_a  = sh16 ? (m_max << 16) : m_max;
    sh8  = (m_a[MW-1 -: 8] == '0);
    m_b  = sh8 ? (m_a << 8) : m_a;
    for (int i = 0; i < 3; i++) begin
      t16[i]  = sh16 ? (mag0_r[i] << 16) : mag0_r[i];
      mag1[i] = sh8 ? (t16[i] << 8) : t16[i];
    end
  end

  always_ff @(posedge clk) begin
    v1_r    <= rst_n ? v0_r : 1'b0;
    m1_r    <= m_b;
    mag1_r  <= mag1;
    neg1_r  <= neg0_r;
    zero1_r <= (m_max == '0);
  end

  // stage 2: fine normalising shifts
  logic [MW-1:0]      m_c, m_d;
  logic               sh4, sh2, sh1;
  logic [2:0][MW-1:0] t4, t2, mag2;
  ucarry_t            c2_r;
  logic               v2_r;

  always_comb begin
    sh4 = (m1_r[MW-1 -: 4] == '0);
    m_c = sh4 ? (m1_r << 4) : m1_r;
    sh2 = (m_c[MW-1 -: 2] == '0);
    m_d = sh2 ? (m_c << 2) : m_c;
    sh1 = ~m_d[MW-1];
    for (int i = 0; i < 3; i++) begin
      t4[i]   = sh4 ? (mag1_r[i] << 4) : mag1_r[i];
      t2[i]   = sh2 ? (t4[i] << 2) : t4[i];
      mag2[i] = sh1 ? (t2[i] << 1) : t2[i];
    end
  end

  always_ff @(posedge clk) begin
    v2_r      <= rst_n ? v1_r : 1'b0;
    c2_r.mag  <= mag2;
    c2_r.neg  <= neg1_r;
    c2_r.zero <= zero1_r;
  end

  // stage 3: squares
  logic [2:0][SQ_W-1:0] sq3_r;
  ucarry_t              c3_r;
  logic                 v3_r;

  always_ff @(posedge clk) begin
    v3_r <= rst_n ? v2_r : 1'b0;
    c3_r <= c2_r;
    for (int i = 0; i < 3; i++) begin
      sq3_r[i] <= c2_r.mag[i] * c2_r.mag[i];
    end
  end

  // stage 4: sum of squares, loads the root pipeline
  logic [SUM_W-1:0]  sq_x_r    [ROOT_W+1];
  logic [REM_W-1:0]  sq_rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root_r [ROOT_W+1];
  ucarry_t           sq_c_r    [ROOT_W+1];
  logic              sq_v_r    [ROOT_W+1];

  always_ff @(posedge clk) begin
    sq_v_r[0]    <= rst_n ? v3_r : 1'b0;
    sq_x_r[0]    <= SUM_W'(sq3_r[0]) + SUM_W'(sq3_r[1]) + SUM_W'(sq3_r[2]);
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_c_r[0]    <= c3_r;
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_t, trial;
    logic             ge;

    assign rem_t = {sq_rem_r[k][REM_W-3:0], sq_x_r[k][SUM_W-1 -: 2]};
    assign trial = {1'b0, sq_root_r[k], 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk) begin
      sq_v_r[k+1]    <= rst_n ? sq_v_r[k] : 1'b0;
      sq_x_r[k+1]    <= sq_x_r[k] << 2;
      sq_rem_r[k+1]  <= ge ? (rem_t - trial) : rem_t;
      sq_root_r[k+1] <= {sq_root_r[k][ROOT_W-2:0], ge};
      sq_c_r[k+1]    <= sq_c_r[k];
    end
  end

  // division of each scaled magnitude by the length, one quotient bit per stage
  logic [2:0][DIV_W-1:0] dv_rem_r [QW];
  logic [2:0][QW-1:0]    dv_q_r   [QW];
  logic [ROOT_W-1:0]     dv_len_r [QW];
  ucarry_t               dv_c_r   [QW];
  logic                  dv_v_r   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][DIV_W-1:0] rin, cand, rout;
    logic [2:0][QW-1:0]    qin, qout;
    logic [ROOT_W-1:0]     lin;
    ucarry_t               cin;
    logic                  vin;

    if (j == 0) begin : g_first
      assign lin = sq_root_r[ROOT_W];
      assign cin = sq_c_r[ROOT_W];
      assign vin = sq_v_r[ROOT_W];
      for (genvar i = 0; i < 3; i++) begin : g_ld
        assign rin[i]  = DIV_W'(sq_c_r[ROOT_W].mag[i]);
        assign qin[i]  = '0;
        assign cand[i] = rin[i];
      end
    end else begin : g_next
      assign lin = dv_len_r[j-1];
      assign cin = dv_c_r[j-1];
      assign vin = dv_v_r[j-1];
      for (genvar i = 0; i < 3; i++) begin : g_ld
        assign rin[i]  = dv_rem_r[j-1][i];
        assign qin[i]  = dv_q_r[j-1][i];
        assign cand[i] = rin[i] << 1;
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (cand[i] >= DIV_W'(lin)) begin
          rout[i] = cand[i] - DIV_W'(lin);
          qout[i] = {qin[i][QW-2:0], 1'b1};
        end else begin
          rout[i] = cand[i];
          qout[i] = {qin[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      dv_v_r[j]   <= rst_n ? vin : 1'b0;
      dv_rem_r[j] <= rout;
      dv_q_r[j]   <= qout;
      dv_len_r[j] <= lin;
      dv_c_r[j]   <= cin;
    end
  end

  // sign back on, zero vector gives zero
  logic [2:0][UW-1:0] unit_r;
  logic               uv_r;
  ucarry_t            cf;

  assign cf = dv_c_r[QW-1];

  always_ff @(posedge clk) begin
    uv_r <= rst_n ? dv_v_r[QW-1] : 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (cf.zero) begin
        unit_r[i] <= '0;
      end else if (cf.neg[i]) begin
        unit_r[i] <= UW'(0) - UW'(dv_q_r[QW-1][i]);
      end else begin
        unit_r[i] <= UW'(dv_q_r[QW-1][i]);
      end
    end
  end

  assign out_valid = uv_r;
  assign unit      = unit_r;

endmodule

`default_nettype wire

// File: sv/phong_light_intensity.sv
// Phong light intensity, top level: configuration registers, vector set-up,
// lighting arithmetic and output. Depends on plint_pkg and plint_unitize.
//
// Use: a surface sample (point and unnormalised normal, camera space) is
// taken at every clock edge where start is high; busy is always low, so a
// new sample may be offered in every cycle. Each sample gives one intensity
// word on out_intensity, marked by out_valid for one cycle. Throughput is
// one sample per cycle; latency is set by the normaliser, whose square
// root (29 stages) and divider (17 stages) work one bit per pipeline
// stage, followed by dot products, the reflection and a six-stage
// square-and-multiply power.
// The receiver cannot stall: results leave in order, one per taken sample.
// Configuration words arrive on the cfg_ channel (cfg_ready is always high)
// and should be written only while the pipeline is empty.
// Reset (rst_n low, synchronous) clears every pipeline valid bit and loads
// the register defaults; no clearing pass is needed.
`default_nettype none

module phong_light_intensity import plint_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [IN_W-1:0] in_point_x,
  input  logic signed [IN_W-1:0] in_point_y,
  input  logic signed [IN_W-1:0] in_point_z,
  input  logic signed [IN_W-1:0] in_normal_x,
  input  logic signed [IN_W-1:0] in_normal_y,
  input  logic signed [IN_W-1:0] in_normal_z,
  output logic                   out_valid,
  output logic [OUT_W-1:0]       out_intensity,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef struct packed {
    logic [QW-1:0] nlc;   // clamped diffuse cosine
    logic          opp;   // eye and light on opposite sides
  } tail_t;

  // configuration registers
  logic [WT_W-1:0]  amb_r, dm_r;
  logic [POW_W-1:0] pow_r;
  logic [IN_W-1:0]  lx_r, ly_r, lz_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amb_r <= RST_AMBIENT;
      dm_r  <= RST_DIFFUSE;
      pow_r <= RST_SPECULAR;
      lx_r  <= RST_LIGHT_X;
      ly_r  <= RST_LIGHT_Y;
      lz_r  <= RST_LIGHT_Z;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_AMBIENT:  amb_r <= cfg_data[WT_W-1:0];
        CFG_DIFFUSE:  dm_r  <= cfg_data[WT_W-1:0];
        CFG_SPECULAR: pow_r <= cfg_data[POW_W-1:0];
        CFG_LIGHT_X:  lx_r  <= cfg_data[IN_W-1:0];
        CFG_LIGHT_Y:  ly_r  <= cfg_data[IN_W-1:0];
        CFG_LIGHT_Z:  lz_r  <= cfg_data[IN_W-1:0];
        default: ;
      endcase
    end
  end

  // set-up stage: normal, eye and light vectors
  logic [2:0][IN_W-1:0] pt, nt, lt;
  logic [2:0][VW-1:0]   nv_r, ev_r, lv_r;
  logic                 sv_r;

  assign pt = {in_point_z, in_point_y, in_point_x};
  assign nt = {in_normal_z, in_normal_y, in_normal_x};
  assign lt = {lz_r, ly_r, lx_r};

  always_ff @(posedge clk) begin
    sv_r <= rst_n ? (start && !busy) : 1'b0;
    for (int i = 0; i < 3; i++) begin
      nv_r[i] <= {nt[i][IN_W-1], nt[i]};
      ev_r[i] <= VW'(0) - {pt[i][IN_W-1], pt[i]};
      lv_r[i] <= {lt[i][IN_W-1], lt[i]} - {pt[i][IN_W-1], pt[i]};
    end
  end

  // normalisers
  logic [2:0][UW-1:0] n_u, e_u, l_u;
  logic               vn, ve, vl;

  plint_unitize u_unit_n (.clk(clk), .rst_n(rst_n), .in_valid(sv_r), .vec(nv_r),
                          .out_valid(vn), .unit(n_u));
  plint_unitize u_unit_e (.clk(clk), .rst_n(rst_n), .in_valid(sv_r), .vec(ev_r),
                          .out_valid(ve), .unit(e_u));
  plint_unitize u_unit_l (.clk(clk), .rst_n(rst_n), .in_valid(sv_r), .vec(lv_r),
                          .out_valid(vl), .unit(l_u));

  // T1: products for N.L and E.N
  logic signed [2*UW-1:0] pnl1_r [3];
  logic signed [2*UW-1:0] pen1_r [3];
  logic signed [UW-1:0]   n1_r [3];
  logic signed [UW-1:0]   e1_r [3];
  logic signed [UW-1:0]   l1_r [3];
  logic                   v1_r;

  always_ff @(posedge clk) begin
    v1_r <= rst_n ? (vn && ve && vl) : 1'b0;
    for (int i = 0; i < 3; i++) begin
      pnl1_r[i] <= $signed(n_u[i]) * $signed(l_u[i]);
      pen1_r[i] <= $signed(e_u[i]) * $signed(n_u[i]);
      n1_r[i]   <= $signed(n_u[i]);
      e1_r[i]   <= $signed(e_u[i]);
      l1_r[i]   <= $signed(l_u[i]);
    end
  end

  // T2: dot products
  logic signed [TW-1:0]    snl, sen;
  logic signed [DOT_W-1:0] nl2_r, en2_r;
  logic signed [UW-1:0]    n2_r [3];
  logic signed [UW-1:0]    e2_r [3];
  logic signed [UW-1:0]    l2_r [3];
  logic                    v2_r;

  assign snl = trunc_frac(TW'(pnl1_r[0]) + TW'(pnl1_r[1]) + TW'(pnl1_r[2]));
  assign sen = trunc_frac(TW'(pen1_r[0]) + TW'(pen1_r[1]) + TW'(pen1_r[2]));

  always_ff @(posedge clk) begin
    v2_r  <= rst_n ? v1_r : 1'b0;
    nl2_r <= DOT_W'(snl);
    en2_r <= DOT_W'(sen);
    n2_r  <= n1_r;
    e2_r  <= e1_r;
    l2_r  <= l1_r;
  end

  // T3: reflection products, side tests, diffuse cosine
  logic signed [DOT_W+UW-1:0] pr3_r [3];
  logic signed [UW-1:0]       e3_r [3];
  logic signed [UW-1:0]       l3_r [3];
  tail_t                      t3_r;
  logic                       v3_r;
  logic                       en_neg, en_pos, nl_neg, nl_pos;
  logic signed [DOT_W-1:0]    nlf;

  assign en_neg = en2_r[DOT_W-1];
  assign en_pos = !en2_r[DOT_W-1] && (en2_r != '0);
  assign nl_neg = nl2_r[DOT_W-1];
  assign nl_pos = !nl2_r[DOT_W-1] && (nl2_r != '0);
  // both behind the surface: flip the normal
  assign nlf    = (en_neg && nl_neg) ? (DOT_W'(0) - nl2_r) : nl2_r;

  always_ff @(posedge clk) begin
    v3_r     <= rst_n ? v2_r : 1'b0;
    for (int i = 0; i < 3; i++) begin
      pr3_r[i] <= nl2_r * n2_r[i];
    end
    e3_r     <= e2_r;
    l3_r     <= l2_r;
    t3_r.nlc <= clamp_unit(TW'(nlf));
    t3_r.opp <= (en_neg && nl_pos) || (en_pos && nl_neg);
  end

  // T4: reflected light vector
  logic signed [TW-1:0]   rr [3];
  logic signed [RV_W-1:0] r4_r [3];
  logic signed [UW-1:0]   e4_r [3];
  tail_t                  t4_r;
  logic                   v4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rr[i] = trunc_frac(TW'(pr3_r[i]) <<< 1) - TW'(l3_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    v4_r <= rst_n ? v3_r : 1'b0;
    for (int i = 0; i < 3; i++) begin
      r4_r[i] <= RV_W'(rr[i]);
    end
    e4_r <= e3_r;
    t4_r <= t3_r;
  end

  // T5: products for R.E
  logic signed [RV_W+UW-1:0] pre5_r [3];
  tail_t                     t5_r;
  logic                      v5_r;

  always_ff @(posedge clk) begin
    v5_r <= rst_n ? v4_r : 1'b0;
    for (int i = 0; i < 3; i++) begin
      pre5_r[i] <= r4_r[i] * e4_r[i];
    end
    t5_r <= t4_r;
  end

  // T6: clamped specular cosine, loads the power pipeline
  logic [QW-1:0] pw_r [POW_W+1];
  logic [QW-1:0] bs_r [POW_W+1];
  tail_t         pt_r [POW_W+1];
  logic          pv_r [POW_W+1];
  logic signed [TW-1:0] sre;

  assign sre = trunc_frac(TW'(pre5_r[0]) + TW'(pre5_r[1]) + TW'(pre5_r[2]));

  always_ff @(posedge clk) begin
    pv_r[0] <= rst_n ? v5_r : 1'b0;
    pw_r[0] <= QW'(ONE);
    bs_r[0] <= clamp_unit(sre);
    pt_r[0] <= t5_r;
  end

  // square and multiply, one exponent bit per stage from the lowest
  for (genvar k = 0; k < POW_W; k++) begin : g_pow
    logic [QMW-1:0] pm, bm;

    assign pm = qmul(QMW'(pw_r[k]), QMW'(bs_r[k]));
    assign bm = qmul(QMW'(bs_r[k]), QMW'(bs_r[k]));

    always_ff @(posedge clk) begin
      pv_r[k+1] <= rst_n ? pv_r[k] : 1'b0;
      pw_r[k+1] <= pow_r[k] ? QW'(pm) : pw_r[k];
      bs_r[k+1] <= QW'(bm);
      pt_r[k+1] <= pt_r[k];
    end
  end

  // W: diffuse and specular terms
  logic [WS_W-1:0] wsum;
  logic [QW-1:0]   weight;
  logic [QMW-1:0]  diff, spec;
  logic [QMW-1:0]  diff_r, spec_r;
  logic            vw_r;
  tail_t           tw;

  assign tw     = pt_r[POW_W];
  assign wsum   = WS_W'(ONE) - WS_W'(amb_r) - WS_W'(dm_r);
  assign weight = wsum[WS_W-1] ? '0 : wsum[QW-1:0];
  assign diff   = qmul(QMW'(dm_r), QMW'(tw.nlc));
  assign spec   = qmul(QMW'(weight), QMW'(pw_r[POW_W]));

  always_ff @(posedge clk) begin
    vw_r   <= rst_n ? pv_r[POW_W] : 1'b0;
    diff_r <= tw.opp ? '0 : diff;
    spec_r <= tw.opp ? '0 : spec;
  end

  // final sum, saturated
  logic [QMW+1:0]   total;
  logic [OUT_W-1:0] out_r;
  logic             ov_r;

  assign total = (QMW+2)'(amb_r) + (QMW+2)'(diff_r) + (QMW+2)'(spec_r);

  always_ff @(posedge clk) begin
    ov_r  <= rst_n ? vw_r : 1'b0;
    out_r <= (total > (QMW+2)'(OUT_LIM)) ? OUT_W'(OUT_LIM) : OUT_W'(total);
  end

  assign out_valid     = ov_r;
  assign out_intensity = out_r;

endmodule

`default_nettype wire

// File: sv/plint_checker.sv
// Port-level checks for the Phong light intensity block, bound to the top
// level. Depends on plint_pkg.
`default_nettype none

module plint_checker import plint_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [OUT_W-1:0] out_intensity
);

  // every taken sample gives a word after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("result word missing after accepted sample");

  // no word without a sample taken that long ago
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result word without accepted sample");

  // intensity never above one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_intensity <= OUT_W'(OUT_LIM)))
    else $error("intensity above saturation level");

endmodule

bind phong_light_intensity plint_checker u_plint_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_valid(out_valid),
  .out_intensity(out_intensity)
);

`default_nettype wire

// File: dv/phong_light_intensity_tb.sv
// Self-checking testbench for phong_light_intensity: directed table, then
// random surface samples over several register settings. Depends on plint_pkg.
`timescale 1ns / 1ps

module phong_light_intensity_tb;
  import plint_pkg::*;

  typedef logic signed [IN_W-1:0] comp_t;

  typedef struct {
    comp_t            px, py, pz, nx, ny, nz;
    bit               has_lit;
    logic [OUT_W-1:0] lit;
  } sample_row_t;

  localparam int WDOG_LIMIT = 4000;
  localparam int NUM_DIRECTED = 14;
  localparam int NUM_PHASES = 6;
  localparam int PER_PHASE = 76;

  logic clk, rst_n, start, busy, out_valid, cfg_valid, cfg_ready;
  comp_t in_point_x, in_point_y, in_point_z, in_normal_x, in_normal_y, in_normal_z;
  logic [OUT_W-1:0]      out_intensity;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow copy of the lighting registers
  longint ambient_q, diffuse_q, power_q, light_q[3];

  logic [OUT_W-1:0] intensity_due[$];
  int               err_count;
  int               idle_cycles;

  sample_row_t directed_rows[NUM_DIRECTED];

  phong_light_intensity u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_normal_x(in_normal_x), .in_normal_y(in_normal_y), .in_normal_z(in_normal_z),
    .out_valid(out_valid), .out_intensity(out_intensity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint absl(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // bring a vector to unit length; pre-scale by a power of two to 2^27
  function automatic void normalise(input longint v[3], output longint u[3]);
    longint peak, scale, s[3];
    longint unsigned sq, len;
    peak = absl(v[0]);
    if (absl(v[1]) > peak) peak = absl(v[1]);
    if (absl(v[2]) > peak) peak = absl(v[2]);
    if (peak == 0) begin
      u = '{0, 0, 0};
      return;
    end
    scale = 1;
    while (peak * scale < (64'sd1 << 27)) scale = scale * 2;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      s[i] = v[i] * scale;
      sq = sq + longint'(s[i] * s[i]);
    end
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) u[i] = (s[i] * ONE) / longint'(len);
  endfunction

  function automatic longint dotq(input longint a[3], input longint b[3]);
    return (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) / ONE;
  endfunction

  function automatic longint clamp_one(input longint x);
    return (x < 0) ? 0 : ((x > ONE) ? ONE : x);
  endfunction

  function automatic longint mulq(input longint a, input longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic logic [OUT_W-1:0] shade(input comp_t px, py, pz, nx, ny, nz);
    longint nv[3], ev[3], lv[3], n[3], e[3], l[3], r[3];
    longint nl, en, ln, diff, spec, pw, base, weight, total;
    nv = '{longint'(nx), longint'(ny), longint'(nz)};
    ev = '{-longint'(px), -longint'(py), -longint'(pz)};
    lv = '{light_q[0] - longint'(px), light_q[1] - longint'(py), light_q[2] - longint'(pz)};
    normalise(nv, n);
    normalise(ev, e);
    normalise(lv, l);
    nl = dotq(n, l);
    for (int i = 0; i < 3; i++) r[i] = (2 * nl * n[i]) / ONE - l[i];
    en = dotq(e, n);
    ln = nl;
    // eye and light both behind: flip the normal
    if (en < 0 && ln < 0) nl = -nl;
    diff = mulq(diffuse_q, clamp_one(nl));
    base = clamp_one(dotq(r, e));
    pw = ONE;
    for (int i = 0; i < POW_W; i++) begin
      if (power_q[i]) pw = mulq(pw, base);
      base = mulq(base, base);
    end
    weight = ONE - ambient_q - diffuse_q;
    if (weight < 0) weight = 0;
    spec = mulq(weight, pw);
    // eye and light on opposite sides: no diffuse, no highlight
    if ((en < 0 && ln > 0) || (en > 0 && ln < 0)) begin
      diff = 0;
      spec = 0;
    end
    total = ambient_q + diff + spec;
    if (total > OUT_LIM) total = OUT_LIM;
    return OUT_W'(total);
  endfunction

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      ambient_q = RST_AMBIENT;
      diffuse_q = RST_DIFFUSE;
      power_q   = RST_SPECULAR;
      light_q   = '{longint'(signed'(RST_LIGHT_X)), longint'(signed'(RST_LIGHT_Y)),
                    longint'(signed'(RST_LIGHT_Z))};
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (cfg_valid && cfg_ready) begin
        idle_cycles = 0;
        case (cfg_index)
          CFG_AMBIENT:  ambient_q = cfg_data[WT_W-1:0];
          CFG_DIFFUSE:  diffuse_q = cfg_data[WT_W-1:0];
          CFG_SPECULAR: power_q = cfg_data[POW_W-1:0];
          CFG_LIGHT_X:  light_q[0] = longint'(signed'(cfg_data));
          CFG_LIGHT_Y:  light_q[1] = longint'(signed'(cfg_data));
          CFG_LIGHT_Z:  light_q[2] = longint'(signed'(cfg_data));
          default: ;
        endcase
      end
      if (out_valid) begin
        idle_cycles = 0;
        if (intensity_due.size() == 0) begin
          $error("intensity: no word expected, got %0d", out_intensity);
          err_count++;
        end else begin
          if (out_intensity !== intensity_due[0]) begin
            $error("intensity: expected %0d, got %0d", intensity_due[0], out_intensity);
            err_count++;
          end
          void'(intensity_due.pop_front());
        end
      end
      if (start && !busy) begin
        idle_cycles = 0;
        intensity_due.push_back(shade(in_point_x, in_point_y, in_point_z,
                                      in_normal_x, in_normal_y, in_normal_z));
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("phong_light_intensity_tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- driving
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_sample(input comp_t px, py, pz, nx, ny, nz);
    @(negedge clk);
    start = 1'b1;
    in_point_x = px; in_point_y = py; in_point_z = pz;
    in_normal_x = nx; in_normal_y = ny; in_normal_z = nz;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
    @(negedge clk);
    start = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (intensity_due.size() != 0) @(posedge clk);
  endtask

  function automatic comp_t rand_comp();
    return comp_t'($urandom());
  endfunction

  // mostly a visible point with a normal roughly facing the eye
  task automatic send_random();
    int mode, shift;
    comp_t px, py, pz, nx, ny, nz;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      px = rand_comp(); py = rand_comp(); pz = rand_comp();
      nx = rand_comp(); ny = rand_comp(); nz = rand_comp();
    end else if (mode < 9) begin
      px = comp_t'($urandom_range(0, 200 << 16)) - comp_t'(100 << 16);
      py = comp_t'($urandom_range(0, 200 << 16)) - comp_t'(100 << 16);
      pz = -comp_t'($urandom_range(1 << 12, 300 << 16));
      shift = $urandom_range(0, 20);
      nx = (comp_t'($urandom_range(0, 2 << 16)) - comp_t'(1 << 16)) >>> shift;
      ny = (comp_t'($urandom_range(0, 2 << 16)) - comp_t'(1 << 16)) >>> shift;
      nz = comp_t'($urandom_range(0, 3 << 16)) - comp_t'(1 << 16);
      nz = nz >>> shift;
    end else begin
      px = comp_t'($urandom_range(0, 6)) - 3; py = comp_t'($urandom_range(0, 6)) - 3;
      pz = comp_t'($urandom_range(0, 6)) - 3; nx = comp_t'($urandom_range(0, 2)) - 1;
      ny = comp_t'($urandom_range(0, 2)) - 1; nz = comp_t'($urandom_range(0, 2)) - 1;
    end
    send_sample(px, py, pz, nx, ny, nz);
    idle_for(pick_gap());
  endtask

  // ---------------------------------------------------------------- stimulus
  localparam comp_t CMAX = 28'sh7FFFFFF;
  localparam comp_t CMIN = -28'sh8000000;
  localparam comp_t Q1   = 28'sd65536;

  longint phase_regs[NUM_PHASES][6] = '{
    '{0, 0, 1, 0, 0, 0},
    '{65536, 65536, 63, 28'sh7FFFFFF, -28'sh8000000, 28'sh7FFFFFF},
    '{131071, 131071, 0, -28'sh8000000, 28'sh7FFFFFF, -28'sh8000000},
    '{0, 65536, 2, 0, 0, -6553600},
    '{6553, 20000, 17, -3276800, 655360, 0},
    '{13107, 32768, 30, 6553600, 6553600, -3276800}
  };

  initial begin
    start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_point_x = '0; in_point_y = '0; in_point_z = '0;
    in_normal_x = '0; in_normal_y = '0; in_normal_z = '0;
    err_count = 0;

    // literal rows: zero normal with point at the eye leaves ambient alone
    directed_rows = '{
      '{0, 0, 0, 0, 0, 0, 1'b1, 17'd13107},
      '{0, 0, -10 * Q1, 0, 0, 0, 1'b0, 0},
      '{0, 0, -10 * Q1, 0, 0, Q1, 1'b0, 0},
      '{0, 0, -10 * Q1, 0, 0, -Q1, 1'b0, 0},
      '{100 * Q1, 100 * Q1, -50 * Q1, 0, 0, Q1, 1'b0, 0},
      '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0, 0},
      '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b0, 0},
      '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 1'b0, 0},
      '{0, 0, -Q1, 1, 0, 0, 1'b0, 0},
      '{0, 0, -Q1, 0, 0, 1, 1'b0, 0},
      '{50 * Q1, 50 * Q1, -100 * Q1, -Q1, -Q1, Q1, 1'b0, 0},
      '{0, 0, 20 * Q1, 0, 0, -Q1, 1'b0, 0},
      '{0, 0, 20 * Q1, 0, 0, Q1, 1'b0, 0},
      '{-1, -1, -1, CMIN, 0, 0, 1'b0, 0}
    };

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table at reset settings
    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].px, directed_rows[i].py, directed_rows[i].pz,
                  directed_rows[i].nx, directed_rows[i].ny, directed_rows[i].nz);
      // let the monitor queue this word first
      #1;
      if (directed_rows[i].has_lit && directed_rows[i].lit !== intensity_due[$]) begin
        $error("intensity: expected %0d, predicted %0d", directed_rows[i].lit,
               intensity_due[$]);
        err_count++;
      end
      idle_for(pick_gap());
    end
    repeat (PER_PHASE) send_random();

    // register sweeps, each written with the pipeline empty
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_reg(CFG_AMBIENT, phase_regs[ph][0]);
      write_reg(CFG_DIFFUSE, phase_regs[ph][1]);
      write_reg(CFG_SPECULAR, phase_regs[ph][2]);
      write_reg(CFG_LIGHT_X, phase_regs[ph][3]);
      write_reg(CFG_LIGHT_Y, phase_regs[ph][4]);
      write_reg(CFG_LIGHT_Z, phase_regs[ph][5]);
      repeat (PER_PHASE / 2) begin
        send_random();
      end
      // back-to-back burst
      repeat (PER_PHASE / 2) begin
        send_sample(rand_comp(), rand_comp(), -comp_t'($urandom_range(1, 1 << 22)),
                    rand_comp() >>> 8, rand_comp() >>> 8, comp_t'($urandom_range(1, 1 << 16)));
      end
    end

    drain();
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (err_count == 0 && intensity_due.size() == 0) begin
      $display("phong_light_intensity_tb: done, clean");
    end else begin
      $display("phong_light_intensity_tb: done, errors");
    end
    $finish;
  end

endmodule
